### rtl/d128_pkg.sv
// Package for the 128-bit signed/unsigned restoring divider.
// Holds the data widths, the pipeline stage record and the arithmetic helpers.
// No dependencies.
package d128_pkg;

    localparam int WORD_W = 64;
    localparam int DATA_W = 2 * WORD_W;
    localparam int STEPS  = DATA_W;

    typedef logic [DATA_W-1:0] word_t;

    // Payload carried by one pipeline stage.
    typedef struct packed {
        logic  neg_q;
        logic  neg_r;
        logic  dbz;
        word_t rem;
        word_t aq;
        word_t dvs;
    } stage_t;

    // Partial remainder and combined dividend/quotient word after one step.
    typedef struct packed {
        word_t rem;
        word_t aq;
    } step_t;

    // Finished item waiting on the result channel.
    typedef struct packed {
        word_t quo;
        word_t rmd;
        logic  dbz;
    } result_t;

    // Two's complement negation of a 128-bit word.
    function automatic word_t negate(input word_t x);
        return ~x + word_t'(1);
    endfunction

    // One restoring step: shift the next dividend bit into the partial
    // remainder, subtract the divisor if it fits and shift in the quotient bit.
    function automatic step_t div_step(input word_t rem, input word_t aq, input word_t dvs);
        logic [DATA_W:0]   part;
        logic [DATA_W+1:0] diff;
        step_t             res;
        part = {rem, aq[DATA_W-1]};
        diff = {1'b0, part} - {2'b00, dvs};
        if (!diff[DATA_W+1]) begin
            res.rem = diff[DATA_W-1:0];
            res.aq  = {aq[DATA_W-2:0], 1'b1};
        end else begin
            res.rem = part[DATA_W-1:0];
            res.aq  = {aq[DATA_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

### rtl/divide_128_signed_unsigned_core.sv
// Items pass an operand magnitude stage, then one stage per restoring step (128 steps),
// then a two-entry output buffer, whose output register drives the m_ ports. One item
// per cycle is accepted while s_ready is high.
// s_ready drops only while both output entries are full.
// Reset (aresetn low, synchronous) clears all valid bits; no result is pending after it.
// Top level of the divider; uses d128_pkg for types, step and negate functions.
module divide_128_signed_unsigned_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_cmd,
    input  logic [d128_pkg::WORD_W-1:0] s_dividend_hi,
    input  logic [d128_pkg::WORD_W-1:0] s_dividend_lo,
    input  logic [d128_pkg::WORD_W-1:0] s_divisor_hi,
    input  logic [d128_pkg::WORD_W-1:0] s_divisor_lo,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [d128_pkg::WORD_W-1:0] m_quotient_hi,
    output logic [d128_pkg::WORD_W-1:0] m_quotient_lo,
    output logic [d128_pkg::WORD_W-1:0] m_remainder_hi,
    output logic [d128_pkg::WORD_W-1:0] m_remainder_lo,
    output logic                       m_divide_by_zero
);

    localparam int STEPS = d128_pkg::STEPS;

    d128_pkg::stage_t  st_reg  [0:STEPS];
    d128_pkg::stage_t  st_next [0:STEPS];
    logic [STEPS:0]    vld_reg;
    logic              advance;

    d128_pkg::word_t   dividend_raw;
    d128_pkg::word_t   divisor_raw;
    logic              sgn_a;
    logic              sgn_b;

    d128_pkg::result_t res_new;
    d128_pkg::result_t out_reg, out_next;
    d128_pkg::result_t skid_reg, skid_next;
    logic              out_vld_reg, out_vld_next;
    logic              skid_vld_reg, skid_vld_next;
    logic              take;
    logic              push;

    // The whole pipeline moves together unless the output buffer is full.
    assign advance = !skid_vld_reg;
    assign s_ready = advance;

    // Operand stage: reduce signed operands to magnitudes.
    always_comb begin
        dividend_raw      = {s_dividend_hi, s_dividend_lo};
        divisor_raw       = {s_divisor_hi, s_divisor_lo};
        sgn_a             = s_cmd & s_dividend_hi[d128_pkg::WORD_W-1];
        sgn_b             = s_cmd & s_divisor_hi[d128_pkg::WORD_W-1];
        st_next[0].neg_q  = sgn_a ^ sgn_b;
        st_next[0].neg_r  = sgn_a;
        st_next[0].dbz    = (divisor_raw == '0);
        st_next[0].rem    = '0;
        st_next[0].aq     = sgn_a ? d128_pkg::negate(dividend_raw) : dividend_raw;
        st_next[0].dvs    = sgn_b ? d128_pkg::negate(divisor_raw) : divisor_raw;
    end

    // One restoring step per stage.
    for (genvar i = 0; i < STEPS; i++) begin : g_step
        d128_pkg::step_t stp;

        always_comb begin
            stp              = d128_pkg::div_step(st_reg[i].rem, st_reg[i].aq, st_reg[i].dvs);
            st_next[i+1]     = st_reg[i];
            st_next[i+1].rem = stp.rem;
            st_next[i+1].aq  = stp.aq;
        end
    end

    // Stage payload registers.
    for (genvar i = 0; i <= STEPS; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (advance) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[STEPS-1:0], s_valid};
        end
    end

    // Sign fix-up of the finished magnitudes.
    always_comb begin
        res_new.quo = st_reg[STEPS].neg_q ? d128_pkg::negate(st_reg[STEPS].aq)
                                          : st_reg[STEPS].aq;
        res_new.rmd = st_reg[STEPS].neg_r ? d128_pkg::negate(st_reg[STEPS].rem)
                                          : st_reg[STEPS].rem;
        res_new.dbz = st_reg[STEPS].dbz;
    end

    // Output register with a skid entry behind it.
    assign take = out_vld_reg & m_ready;
    assign push = advance & vld_reg[STEPS];

    always_comb begin
        out_next      = out_reg;
        skid_next     = skid_reg;
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        if (skid_vld_reg) begin
            if (take) begin
                out_next      = skid_reg;
                skid_vld_next = 1'b0;
            end
        end else if (push) begin
            if (!out_vld_reg || take) begin
                out_next     = res_new;
                out_vld_next = 1'b1;
            end else begin
                skid_next     = res_new;
                skid_vld_next = 1'b1;
            end
        end else if (take) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid          = out_vld_reg;
    assign m_quotient_hi    = out_reg.quo[d128_pkg::DATA_W-1:d128_pkg::WORD_W];
    assign m_quotient_lo    = out_reg.quo[d128_pkg::WORD_W-1:0];
    assign m_remainder_hi   = out_reg.rmd[d128_pkg::DATA_W-1:d128_pkg::WORD_W];
    assign m_remainder_lo   = out_reg.rmd[d128_pkg::WORD_W-1:0];
    assign m_divide_by_zero = out_reg.dbz;

    // A full skid entry always sits behind a valid output entry.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry full while output entry empty");

    // The skid entry drains only when the output entry is taken.
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(skid_vld_reg) |-> $past(m_ready))
        else $error("skid entry drained without an output handshake");

    // With a nonzero divisor the final partial remainder is below the divisor.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[STEPS] && !st_reg[STEPS].dbz) |-> (st_reg[STEPS].rem < st_reg[STEPS].dvs))
        else $error("final remainder magnitude not below divisor");

    // A zero divisor gives an all-ones magnitude quotient.
    a_dbz_quotient: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[STEPS] && st_reg[STEPS].dbz) |-> (st_reg[STEPS].aq == '1))
        else $error("zero divisor did not give an all-ones quotient magnitude");

endmodule
